@@ rtl/arp_pkg.sv @@
// Shared types and codes for the AArch64 relocation patcher.
// No dependencies; imported by every stage and by the top level.
package arp_pkg;

   // Relocation kinds
   localparam logic [4:0] K_ABS64   = 5'd0;
   localparam logic [4:0] K_ABS32   = 5'd1;
   localparam logic [4:0] K_ABS16   = 5'd2;
   localparam logic [4:0] K_PREL64  = 5'd3;
   localparam logic [4:0] K_PREL32  = 5'd4;
   localparam logic [4:0] K_PREL16  = 5'd5;
   localparam logic [4:0] K_ADRP    = 5'd6;
   localparam logic [4:0] K_GOTPAGE = 5'd7;
   localparam logic [4:0] K_ADDLO   = 5'd8;
   localparam logic [4:0] K_LDST8   = 5'd9;
   localparam logic [4:0] K_LDST16  = 5'd10;
   localparam logic [4:0] K_LDST32  = 5'd11;
   localparam logic [4:0] K_LDST64  = 5'd12;
   localparam logic [4:0] K_LDST128 = 5'd13;
   localparam logic [4:0] K_GOTLO   = 5'd14;
   localparam logic [4:0] K_JUMP    = 5'd15;
   localparam logic [4:0] K_CALL    = 5'd16;

   // Store widths
   localparam logic [1:0] SZ2 = 2'd0;
   localparam logic [1:0] SZ4 = 2'd1;
   localparam logic [1:0] SZ8 = 2'd2;

   // Error codes
   localparam logic [2:0] E_OK    = 3'd0;
   localparam logic [2:0] E_RANGE = 3'd1;
   localparam logic [2:0] E_ALIGN = 3'd2;
   localparam logic [2:0] E_SCALE = 3'd3;
   localparam logic [2:0] E_KIND  = 3'd4;
   localparam logic [2:0] E_STUB  = 3'd5;

   // Item after the base + addend stage
   typedef struct packed {
      logic [4:0]  mode;
      logic [63:0] sum;
      logic [63:0] place;
      logic [31:0] word;
   } sum_type;

   // Item after the subtract stage
   typedef struct packed {
      logic [4:0]  mode;
      logic [63:0] value;
      logic [31:0] word;
   } diff_type;

   // Finished result
   typedef struct packed {
      logic [63:0] patch_value;
      logic [1:0]  patch_size;
      logic [2:0]  error_code;
   } result_type;

endpackage

@@ rtl/arp_sum.sv @@
// Stage 1 of the relocation patcher: forms base + addend (S+A or G+A).
// Depends on arp_pkg.
module arp_sum import arp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [4:0]         mode,
   input  logic [63:0]        symbol_addr,
   input  logic signed [63:0] addend,
   input  logic [63:0]        place_addr,
   input  logic [63:0]        got_slot,
   input  logic [31:0]        old_word,
   output logic               out_valid,
   input  logic               out_ready,
   output sum_type            out_item
);

   logic    valid_ff;
   sum_type item_ff;
   sum_type item_in;
   logic    use_got;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      use_got       = (mode == K_GOTPAGE) || (mode == K_GOTLO);
      item_in.mode  = mode;
      item_in.sum   = (use_got ? got_slot : symbol_addr) + $unsigned(addend);
      item_in.place = place_addr;
      item_in.word  = old_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/arp_diff.sv @@
// Stage 2 of the relocation patcher: subtracts the place (or its page) for relative kinds.
// Depends on arp_pkg.
module arp_diff import arp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  sum_type  in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output diff_type out_item
);

   logic        valid_ff;
   diff_type    item_ff;
   diff_type    item_in;
   logic        is_page;
   logic        is_rel;
   logic [63:0] lhs;
   logic [63:0] rhs;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      is_page = (in_item.mode == K_ADRP) || (in_item.mode == K_GOTPAGE);
      is_rel  = is_page || (in_item.mode == K_PREL64) || (in_item.mode == K_PREL32) ||
                (in_item.mode == K_PREL16) || (in_item.mode == K_JUMP) ||
                (in_item.mode == K_CALL);
      // page kinds drop the low 12 bits of both operands
      lhs = is_page ? {in_item.sum[63:12], 12'h000} : in_item.sum;
      rhs = is_page ? {in_item.place[63:12], 12'h000} : in_item.place;
      item_in.mode  = in_item.mode;
      item_in.value = is_rel ? (lhs - rhs) : in_item.sum;
      item_in.word  = in_item.word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/arp_patch.sv @@
// Stage 3 of the relocation patcher: range, alignment and scale checks,
// field insertion and the result register. Depends on arp_pkg.
module arp_patch import arp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  diff_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_item
);

   logic        valid_ff;
   result_type  item_ff;
   result_type  item_in;
   logic [63:0] v;
   logic [31:0] w;
   logic [63:0] val;
   logic [1:0]  size;
   logic [2:0]  err;
   logic        fit32;
   logic        fit16;
   logic        fit33;
   logic        fit28;
   logic [2:0]  sc;
   logic [2:0]  expect_sc;
   logic [11:0] lo12;
   logic [11:0] lo12_scaled;
   logic        misaligned;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      v     = in_item.value;
      w     = in_item.word;
      fit32 = (&v[63:31]) || !(|v[63:31]);
      fit16 = (&v[63:15]) || !(|v[63:15]);
      fit33 = (&v[63:32]) || !(|v[63:32]);
      fit28 = (&v[63:27]) || !(|v[63:27]);
      lo12  = v[11:0];

      // scale encoded in the load/store word
      sc = 3'd0;
      if ((w & 32'h3B000000) == 32'h39000000) begin
         sc = {1'b0, w[31:30]};
         if (w[31:30] == 2'd0 && (w & 32'h04800000) == 32'h04800000) begin
            sc = 3'd4;
         end
      end
      lo12_scaled = lo12 >> sc;

      expect_sc = 3'd0;
      if (in_item.mode == K_GOTLO) begin
         expect_sc = 3'd3;
      end else if (in_item.mode >= K_LDST8 && in_item.mode <= K_LDST128) begin
         expect_sc = 3'(in_item.mode - K_LDST8);
      end
      misaligned = 1'b0;
      case (expect_sc)
         3'd1:    misaligned = v[0];
         3'd2:    misaligned = |v[1:0];
         3'd3:    misaligned = |v[2:0];
         3'd4:    misaligned = |v[3:0];
         default: misaligned = 1'b0;
      endcase

      val  = 64'd0;
      size = SZ4;
      err  = E_OK;
      unique case (in_item.mode) inside
         K_ABS64, K_PREL64: begin
            val  = v;
            size = SZ8;
         end
         K_ABS32, K_PREL32: begin
            val  = {32'd0, v[31:0]};
            size = SZ4;
            if (!fit32) err = E_RANGE;
         end
         K_ABS16, K_PREL16: begin
            val  = {48'd0, v[15:0]};
            size = SZ2;
            if (!fit16) err = E_RANGE;
         end
         K_ADRP, K_GOTPAGE: begin
            if (!fit33) err = E_RANGE;
            val = {32'd0, (w & 32'h9f00001f) | {1'b0, v[13:12], 29'd0} |
                          {8'd0, v[32:14], 5'd0}};
         end
         [K_ADDLO:K_GOTLO]: begin
            if (misaligned) begin
               err = E_ALIGN;
            end else if (lo12 != 12'd0 && sc != expect_sc) begin
               err = E_SCALE;
            end
            val = {32'd0, (w & 32'hffc003ff) | {10'd0, lo12_scaled, 10'd0}};
         end
         K_JUMP, K_CALL: begin
            if (!fit28) err = E_STUB;
            val = {32'd0, w[31:26], v[27:2]};
         end
         default: begin
            err  = E_KIND;
            size = SZ2;
         end
      endcase

      // drop the value on any error
      if (err != E_OK) val = 64'd0;
      item_in.patch_value = val;
      item_in.patch_size  = size;
      item_in.error_code  = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/aarch64_relocation_patcher.sv @@
// Top level of the AArch64 relocation patcher: three pipeline stages.
// Depends on arp_pkg, arp_sum, arp_diff and arp_patch.
//
// One relocation item goes in, one result item comes out. A new item can
// enter on every clock while req_stall is low: the pipeline is three
// register stages (base plus addend, minus place or place page, then checks
// and field insertion into the result register), and each stage takes an item
// whenever it is empty or its content moves on, so bubbles close up while
// the result side stalls and req_stall rises only when all three stages
// hold an item. Throughput is one item per cycle while rsp_stall is low;
// the two 64-bit adders in stages one and two set the clock. A data kind
// returns the truncated value at its store width; an instruction kind
// returns the rewritten word in the low 32 bits. Any nonzero error_code
// comes with a zero patch_value; unsupported kinds give error 4 with the
// two-byte size, and an out-of-range branch gives error 5.
module aarch64_relocation_patcher import arp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_mode,
   input  logic [63:0]        req_symbol_addr,
   input  logic signed [63:0] req_addend,
   input  logic [63:0]        req_place_addr,
   input  logic [63:0]        req_got_slot,
   input  logic [31:0]        req_old_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_patch_value,
   output logic [1:0]         rsp_patch_size,
   output logic [2:0]         rsp_error_code
);

   logic       sum_valid;
   logic       sum_ready;
   sum_type    sum_item;
   logic       diff_valid;
   logic       diff_ready;
   diff_type   diff_item;
   logic       req_ready;
   result_type rsp_item;

   // Stage 1: add the addend to the symbol or GOT slot address
   arp_sum u_sum (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .mode        (req_mode),
      .symbol_addr (req_symbol_addr),
      .addend      (req_addend),
      .place_addr  (req_place_addr),
      .got_slot    (req_got_slot),
      .old_word    (req_old_word),
      .out_valid   (sum_valid),
      .out_ready   (sum_ready),
      .out_item    (sum_item)
   );

   // Stage 2: for relative kinds subtract the place, or the place page for ADRP kinds
   arp_diff u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_item   (sum_item),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .out_item  (diff_item)
   );

   // Stage 3: check, patch and hold the result until taken
   arp_patch u_patch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .in_item   (diff_item),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_item  (rsp_item)
   );

   assign req_stall       = !req_ready;
   assign rsp_patch_value = rsp_item.patch_value;
   assign rsp_patch_size  = rsp_item.patch_size;
   assign rsp_error_code  = rsp_item.error_code;

   // An error result never carries a value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != E_OK |-> rsp_patch_value == 64'd0)
      else $error("error result carries a nonzero value");

   // Narrow stores keep the upper word clear
   a_narrow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_patch_size != SZ8 |-> rsp_patch_value[63:32] == 32'd0)
      else $error("narrow result has upper bits set");

   // Unsupported kind reports the two-byte size
   a_kind_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == E_KIND |-> rsp_patch_size == SZ2)
      else $error("unsupported kind with wrong size");

   // Input side stalls only when the result side is stalled and holds an item
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

endmodule
